/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/stn_pkg.sv */
package stn_pkg;

    localparam int MAX_RES = 4;
    localparam int QDEPTH  = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    localparam logic [7:0] LEAD_EF = 8'hEF;
    localparam logic [7:0] LEAD_E3 = 8'hE3;
    localparam logic [7:0] MID_EF  = 8'hBC;
    localparam logic [7:0] MID_E3  = 8'h80;
    localparam logic [7:0] SPACE   = 8'h20;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;

    // One queue entry: the results caused by one input transaction.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] data;
        logic [CNT_W-1:0]        cnt;
        logic                    bare;
        logic                    last;
    } entry_t;

    // Results gathered so far while an item is examined, plus separator state.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] data;
        logic [CNT_W-1:0]        cnt;
        logic                    sp;
        logic                    ea;
    } acc_t;

    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        case (c) inside
            [8'h09:8'h0D], 8'h20, 8'h3F, 8'h2E, 8'h2C, 8'h3A, 8'h3B,
            8'h21, 8'h22, 8'h27, 8'h28, 8'h29: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_lead(input logic [7:0] c);
        return (c == LEAD_EF) || (c == LEAD_E3);
    endfunction

    function automatic logic is_mid(input logic [7:0] h0, input logic [7:0] c);
        return ((h0 == LEAD_EF) && (c == MID_EF)) || ((h0 == LEAD_E3) && (c == MID_E3));
    endfunction

    function automatic logic is_tail(input logic [7:0] h0, input logic [7:0] c);
        logic r;
        r = 1'b0;
        if (h0 == LEAD_EF) begin
            case (c) inside
                8'h9F, 8'h8C, 8'h9A, 8'h9B, 8'h81, 8'h88, 8'h89: r = 1'b1;
                default: r = 1'b0;
            endcase
        end else if (h0 == LEAD_E3) begin
            case (c) inside
                8'h82, 8'h8A, 8'h8B: r = 1'b1;
                default: r = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic acc_t push(input acc_t a, input logic [7:0] v);
        acc_t r;
        r = a;
        if (r.cnt < CNT_W'(MAX_RES)) begin
            r.data[r.cnt[IDX_W-1:0]] = v;
            r.cnt = r.cnt + 1'b1;
        end
        return r;
    endfunction

    // A byte that is not part of a full CJK mark: separator or text.
    function automatic acc_t plain(input acc_t a, input logic [7:0] c);
        acc_t r;
        r = a;
        if (is_sep(c)) begin
            if (r.ea) begin
                r.sp = 1'b1;
            end
        end else begin
            if (r.sp && r.ea) begin
                r = push(r, SPACE);
            end
            r.sp = 1'b0;
            if ((c >= UPPER_A) && (c <= UPPER_Z)) begin
                r = push(r, c | CASE_BIT);
            end else begin
                r = push(r, c);
            end
            r.ea = 1'b1;
        end
        return r;
    endfunction

endpackage

/* sv/search_text_normalizer_top.sv */
// Path: accepted bytes write their results into the queue, and the back end loads them from
// the queue head into the output register that drives m_valid.
// Throughput: one input byte per cycle and one result per cycle while m_ready is high; a byte
// that causes several results has them sent one by one from its queue entry, and s_ready drops
// only when the four-entry queue between front and back end is full.
// Reset: synchronous, active-low aresetn clears the held prefix, separator state,
// queue and output register; the block is ready in the first cycle after reset.
module search_text_normalizer_top import stn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_end_of_result
);

    logic   q_full;
    logic   q_push;
    entry_t q_entry;
    logic   q_valid;
    entry_t q_head;
    logic   q_pop;

    stn_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    stn_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop)
    );

    stn_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_has_byte      (m_has_byte),
        .m_end_of_result (m_end_of_result)
    );

endmodule

/* sv/stn_front.sv */
`include "assert_macros.svh"

module stn_front import stn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_text,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_entry
);

    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic       space_pending_reg;
    logic       emitted_any_reg;
    logic       accept;
    acc_t       acc;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        acc           = '0;
        acc.sp        = space_pending_reg;
        acc.ea        = emitted_any_reg;
        held_cnt_next = 2'd0;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        case (held_cnt_reg)
            2'd0: begin
                if (is_lead(s_in_byte)) begin
                    held_cnt_next = 2'd1;
                    held0_next    = s_in_byte;
                end else begin
                    acc = plain(acc, s_in_byte);
                end
            end
            2'd1: begin
                if (is_mid(held0_reg, s_in_byte)) begin
                    held_cnt_next = 2'd2;
                    held1_next    = s_in_byte;
                end else begin
                    acc = plain(acc, held0_reg);
                    if (is_lead(s_in_byte)) begin
                        held_cnt_next = 2'd1;
                        held0_next    = s_in_byte;
                    end else begin
                        acc = plain(acc, s_in_byte);
                    end
                end
            end
            2'd2: begin
                if (is_mid(held0_reg, held1_reg) && is_tail(held0_reg, s_in_byte)) begin
                    // A full CJK mark acts as one separator.
                    if (acc.ea) begin
                        acc.sp = 1'b1;
                    end
                end else begin
                    acc = plain(acc, held0_reg);
                    acc = plain(acc, held1_reg);
                    if (is_lead(s_in_byte)) begin
                        held_cnt_next = 2'd1;
                        held0_next    = s_in_byte;
                    end else begin
                        acc = plain(acc, s_in_byte);
                    end
                end
            end
            default: begin
                held_cnt_next = 2'd0;
            end
        endcase

        // At end of text an unfinished prefix goes out as ordinary bytes.
        if (s_end_of_text) begin
            if (held_cnt_next != 2'd0) begin
                acc = plain(acc, held0_next);
            end
            if (held_cnt_next == 2'd2) begin
                acc = plain(acc, held1_next);
            end
        end

        q_entry.data = acc.data;
        q_entry.bare = (acc.cnt == '0);
        q_entry.cnt  = (acc.cnt == '0) ? CNT_W'(1) : acc.cnt;
        q_entry.last = s_end_of_text;
        q_push       = accept && ((acc.cnt != '0) || s_end_of_text);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt_reg      <= 2'd0;
            space_pending_reg <= 1'b0;
            emitted_any_reg   <= 1'b0;
        end else if (accept) begin
            if (s_end_of_text) begin
                held_cnt_reg      <= 2'd0;
                space_pending_reg <= 1'b0;
                emitted_any_reg   <= 1'b0;
            end else begin
                held_cnt_reg      <= held_cnt_next;
                space_pending_reg <= acc.sp;
                emitted_any_reg   <= acc.ea;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    `ASSERT_ALWAYS(a_held_cnt_range, aclk, aresetn, held_cnt_reg != 2'd3)
    `ASSERT_IMPLIES(a_held_is_lead, aclk, aresetn, held_cnt_reg != 2'd0, held0_reg == LEAD_EF || held0_reg == LEAD_E3)
    `ASSERT_IMPLIES(a_space_after_text, aclk, aresetn, space_pending_reg, emitted_any_reg)
    `ASSERT_NEXT(a_end_clears, aclk, aresetn, accept && s_end_of_text, held_cnt_reg == 2'd0 && !emitted_any_reg && !space_pending_reg)

endmodule

/* sv/stn_queue.sv */
module stn_queue import stn_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   head_valid,
    output entry_t head_entry,
    input  logic   pop
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    entry_t              mem_reg [QDEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* sv/stn_back.sv */
`include "assert_macros.svh"

module stn_back import stn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  entry_t     q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_end_of_result
);

    logic             m_valid_reg;
    logic [7:0]       m_out_byte_reg;
    logic             m_has_byte_reg;
    logic             m_end_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             load;
    logic             at_last;
    logic [CNT_W-1:0] last_idx;

    assign last_idx = q_head.cnt - 1'b1;
    assign at_last  = (idx_reg == last_idx[IDX_W-1:0]);
    // The output register is refilled from a waiting queue entry whenever it is empty or being drained.
    assign load     = q_valid && (!m_valid_reg || m_ready);
    assign q_pop    = load && at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= at_last ? '0 : idx_reg + 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_out_byte_reg <= q_head.bare ? 8'h00 : q_head.data[idx_reg];
            m_has_byte_reg <= !q_head.bare;
            m_end_reg      <= q_head.last && at_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_out_byte_reg;
    assign m_has_byte      = m_has_byte_reg;
    assign m_end_of_result = m_end_reg;

    `ASSERT_IMPLIES(a_bare_is_end, aclk, aresetn, m_valid_reg && !m_has_byte_reg, m_end_reg && m_out_byte_reg == 8'h00)
    `ASSERT_IMPLIES(a_idx_in_entry, aclk, aresetn, q_valid, {1'b0, idx_reg} < q_head.cnt)
    `ASSERT_NEXT(a_pop_resets_idx, aclk, aresetn, q_pop, idx_reg == '0)

endmodule
